[design/etp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ELLPACK transpose placer package
// Field widths, status codes and the fill store write control shared by the
// placer top level and its fill counter store.
// ----------------------------------------------------------------------------
package etp_pkg;

  // Item field widths.
  localparam int ROW_W   = 10;
  localparam int SLOT_W  = 6;
  localparam int VALUE_W = 64;
  localparam int FILL_W  = 7;

  // Configuration register widths and reset values.
  localparam int RC_W = 11;
  localparam int RW_W = 7;
  localparam logic [RC_W-1:0] RC_RESET = 11'd1024;
  localparam logic [RW_W-1:0] RW_RESET = 7'd64;

  // Configuration register indexes.
  typedef enum logic {
    REG_ROW_COUNT = 1'b0,
    REG_ROW_WIDTH = 1'b1
  } etp_reg_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_PLACED   = 2'd0,
    ST_ROW_FULL = 2'd1,
    ST_RANGE    = 2'd2
  } etp_status_t;

  // Control that goes with one write into the fill store.
  typedef struct packed {
    logic adv;        // the working item leaves its stage
    logic wr;         // the working item updates one counter row
    logic clear_all;  // the working item starts a new matrix
  } etp_wr_ctl_t;

endpackage

[design/etp_fill_store.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ELLPACK transpose fill counter store
// Per-row fill counters held in a memory of counter groups. Each group has a
// valid bit; a group that is not valid reads as all counters at 1. A one-entry
// bypass covers the write that lands on the same edge as a read.
// ----------------------------------------------------------------------------
module etp_fill_store #(
  parameter  int GROUP = 4,
  parameter  int NGRP  = 256,
  localparam int GAW   = (NGRP > 1) ? $clog2(NGRP) : 1
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  // Read side: group address taken with the item
  input  logic                                      rd_en,
  input  logic [GAW-1:0]                            rd_grp,
  output logic [GROUP-1:0][etp_pkg::FILL_W-1:0]    rd_row,
  // Write side from the working stage
  input  etp_pkg::etp_wr_ctl_t                      wr_ctl,
  input  logic [GAW-1:0]                            wr_grp,
  input  logic [GROUP-1:0][etp_pkg::FILL_W-1:0]    wr_row
);
  import etp_pkg::*;

  logic [GROUP-1:0][FILL_W-1:0] mem [NGRP];
  logic [GROUP-1:0][FILL_W-1:0] rd_data_r;
  logic [GAW-1:0]               rd_grp_r;
  logic [NGRP-1:0]              grp_vld_r;
  logic [NGRP-1:0]              grp_vld_nxt;
  logic                         byp_vld_r;
  logic [GAW-1:0]               byp_grp_r;
  logic [GROUP-1:0][FILL_W-1:0] byp_row_r;
  logic [GROUP-1:0][FILL_W-1:0] ones_row;

  // Memory array with a registered read port.
  always_ff @(posedge clk) begin
    if (wr_ctl.wr) begin
      mem[wr_grp] <= wr_row;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_grp];
      rd_grp_r  <= rd_grp;
    end
  end

  // A new matrix drops every group; the write of the same item marks its own.
  always_comb begin
    grp_vld_nxt = grp_vld_r;
    if (wr_ctl.clear_all) begin
      grp_vld_nxt = '0;
    end
    if (wr_ctl.wr) begin
      grp_vld_nxt[wr_grp] = 1'b1;
    end
  end

  // Group valid bits and the bypass of the latest write.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grp_vld_r <= '0;
      byp_vld_r <= 1'b0;
    end else begin
      grp_vld_r <= grp_vld_nxt;
      if (wr_ctl.adv) begin
        byp_vld_r <= wr_ctl.wr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_ctl.adv) begin
      byp_grp_r <= wr_grp;
      byp_row_r <= wr_row;
    end
  end

  // A fresh group holds every counter at 1.
  always_comb begin
    for (int i = 0; i < GROUP; i++) begin
      ones_row[i] = FILL_W'(1);
    end
  end

  // Resolve the row: bypass first, then the memory if the group is valid.
  always_comb begin
    if (byp_vld_r && (byp_grp_r == rd_grp_r)) begin
      rd_row = byp_row_r;
    end else if (grp_vld_r[rd_grp_r]) begin
      rd_row = rd_data_r;
    end else begin
      rd_row = ones_row;
    end
  end

endmodule

[design/ellpack_transpose_placer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ELLPACK transpose placer
// Maps each stored ELLPACK entry to its place in the transposed matrix using
// per-row fill counters. Diagonal entries keep their row and slot 0.
//
//   Channel   Direction  Handshake        Contents
//   in_       input      tvalid/tready    source entry, new-matrix flag
//   out_      output     tvalid/tready    destination place, status
//   cfg_      input      APB write/read   row_count, row_width
//
// One item per cycle sustained while the output is not stalled; an accepted item
// passes the input stage with the counter read, then the result register, to out_tvalid.
// The counter read-modify-write goes through a write bypass.
// Reset is synchronous; the counters read as 1 right after reset, no sweep.
// A stalled output holds the working stage; the input is taken again as soon
// as the result register frees up.
// ----------------------------------------------------------------------------
module ellpack_transpose_placer #(
  parameter int MAX_ROWS  = 1024,
  parameter int MAX_WIDTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input items
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // src_row[9:0], src_slot[15:10], col_index[25:16],
                                  // entry_value[89:26], zero[95:90]
  input  logic [0:0]  in_tuser,   // new_matrix[0]
  // Result items
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,  // dest_row[9:0], dest_slot[15:10], dest_col[25:16],
                                  // dest_value[89:26], zero[95:90]
  output logic [1:0]  out_tuser,  // status[1:0]
  // Configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import etp_pkg::*;

  // Storage geometry: counters are grouped so that at most 256 groups exist.
  localparam int DEPTH = (MAX_ROWS < 1024) ? MAX_ROWS : 1024;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int GW    = (AW > 8) ? (AW - 8) : 0;
  localparam int GROUP = 1 << GW;
  localparam int LW    = (GW > 0) ? GW : 1;
  localparam int NGRP  = (DEPTH + GROUP - 1) / GROUP;
  localparam int GAW   = (NGRP > 1) ? $clog2(NGRP) : 1;
  localparam int NW    = 17;
  localparam int M_LIM = (MAX_WIDTH < 64) ? MAX_WIDTH : 64;

  // Configuration registers
  logic [RC_W-1:0] row_count_r;
  logic [RW_W-1:0] row_width_r;
  logic            cfg_wr;
  logic [NW-1:0]   n_use;
  logic [RW_W-1:0] m_use;

  // Working stage
  logic               s1_vld_r;
  logic               s1_new_r;
  logic [ROW_W-1:0]   s1_row_r;
  logic [SLOT_W-1:0]  s1_slot_r;
  logic [ROW_W-1:0]   s1_col_r;
  logic [VALUE_W-1:0] s1_val_r;
  logic [LW-1:0]      s1_lane_r;
  logic [GAW-1:0]     s1_grp_r;
  logic               s1_adv;
  logic               in_fire;

  // Input field views
  logic [ROW_W-1:0]   in_row;
  logic [SLOT_W-1:0]  in_slot;
  logic [ROW_W-1:0]   in_col;
  logic [VALUE_W-1:0] in_val;
  logic [AW-1:0]      in_idx;
  logic [GAW-1:0]     in_grp;
  logic [LW-1:0]      in_lane;

  // Counter row handling
  logic [GROUP-1:0][FILL_W-1:0] st_row;
  logic [GROUP-1:0][FILL_W-1:0] cur_row;
  logic [GROUP-1:0][FILL_W-1:0] upd_row;
  logic [FILL_W-1:0]            fill;
  etp_wr_ctl_t                  wr_ctl;

  // Result logic and register
  etp_status_t        res_status;
  logic [ROW_W-1:0]   res_row;
  logic [SLOT_W-1:0]  res_slot;
  logic               range_err;
  logic               row_full;
  logic               off_diag;

  logic               out_vld_r;
  logic [ROW_W-1:0]   out_row_r;
  logic [SLOT_W-1:0]  out_slot_r;
  logic [ROW_W-1:0]   out_col_r;
  logic [VALUE_W-1:0] out_val_r;
  etp_status_t        out_status_r;

  // Configuration port: write in the access phase, reads always ready.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= RC_RESET;
      row_width_r <= RW_RESET;
    end else if (cfg_wr) begin
      case (etp_reg_t'(cfg_paddr[2]))
        REG_ROW_COUNT: row_count_r <= cfg_pwdata[RC_W-1:0];
        REG_ROW_WIDTH: row_width_r <= cfg_pwdata[RW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (etp_reg_t'(cfg_paddr[2]))
      REG_ROW_COUNT: cfg_prdata = 32'(row_count_r);
      REG_ROW_WIDTH: cfg_prdata = 32'(row_width_r);
      default:       cfg_prdata = '0;
    endcase
  end

  // Rows and slots in use, clamped to the storage limits.
  always_comb begin
    if (row_count_r == '0) begin
      n_use = NW'(1);
    end else if (NW'(row_count_r) > NW'(DEPTH)) begin
      n_use = NW'(DEPTH);
    end else begin
      n_use = NW'(row_count_r);
    end
    if (row_width_r == '0) begin
      m_use = RW_W'(1);
    end else if (row_width_r > RW_W'(M_LIM)) begin
      m_use = RW_W'(M_LIM);
    end else begin
      m_use = row_width_r;
    end
  end

  // Input unpacking and counter address.
  assign in_row  = in_tdata[9:0];
  assign in_slot = in_tdata[15:10];
  assign in_col  = in_tdata[25:16];
  assign in_val  = in_tdata[89:26];
  assign in_idx  = AW'(in_col);
  assign in_grp  = GAW'(32'(in_idx) / GROUP);
  assign in_lane = LW'(32'(in_idx) % GROUP);

  // Handshake: the working stage moves when the result register is free.
  assign s1_adv    = s1_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !s1_vld_r || s1_adv;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_fire) begin
      s1_vld_r <= 1'b1;
    end else if (s1_adv) begin
      s1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_new_r  <= in_tuser[0];
      s1_row_r  <= in_row;
      s1_slot_r <= in_slot;
      s1_col_r  <= in_col;
      s1_val_r  <= in_val;
      s1_lane_r <= in_lane;
      s1_grp_r  <= in_grp;
    end
  end

  // Fill counter store, read with the item and written when it leaves.
  etp_fill_store #(
    .GROUP (GROUP),
    .NGRP  (NGRP)
  ) u_fill_store (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_en  (in_fire),
    .rd_grp (in_grp),
    .rd_row (st_row),
    .wr_ctl (wr_ctl),
    .wr_grp (s1_grp_r),
    .wr_row (upd_row)
  );

  // A new matrix sees every counter at 1.
  always_comb begin
    for (int i = 0; i < GROUP; i++) begin
      cur_row[i] = s1_new_r ? FILL_W'(1) : st_row[i];
    end
    fill = cur_row[s1_lane_r];
    upd_row = cur_row;
    upd_row[s1_lane_r] = fill + FILL_W'(1);
  end

  // Placement decision.
  always_comb begin
    off_diag  = (s1_slot_r != '0);
    range_err = (NW'(s1_row_r) >= n_use) || (RW_W'(s1_slot_r) >= m_use) ||
                (off_diag && (NW'(s1_col_r) >= n_use));
    row_full  = off_diag && (fill >= m_use);
    if (range_err) begin
      res_status = ST_RANGE;
    end else if (row_full) begin
      res_status = ST_ROW_FULL;
    end else begin
      res_status = ST_PLACED;
    end
    if (res_status != ST_PLACED) begin
      res_row  = '0;
      res_slot = '0;
    end else if (off_diag) begin
      res_row  = s1_col_r;
      res_slot = fill[SLOT_W-1:0];
    end else begin
      res_row  = s1_row_r;
      res_slot = '0;
    end
    wr_ctl.adv       = s1_adv;
    wr_ctl.wr        = s1_adv && off_diag && (res_status == ST_PLACED);
    wr_ctl.clear_all = s1_adv && s1_new_r;
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s1_adv) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_row_r    <= res_row;
      out_slot_r   <= res_slot;
      out_col_r    <= (res_status == ST_PLACED) ? s1_row_r : '0;
      out_val_r    <= (res_status == ST_PLACED) ? s1_val_r : '0;
      out_status_r <= res_status;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {6'd0, out_val_r, out_col_r, out_slot_r, out_row_r};
  assign out_tuser  = out_status_r;

  // An accepted item always occupies the working stage on the next cycle.
  a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> s1_vld_r)
    else $error("accepted item did not reach the working stage");

  // A placed result stays inside the row width in use.
  a_slot_in_width: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && (out_status_r == ST_PLACED)) |-> (RW_W'(out_slot_r) < m_use))
    else $error("placed slot beyond the row width");

  // A failed placement carries no destination.
  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && (out_status_r != ST_PLACED)) |->
      ((out_row_r == '0) && (out_slot_r == '0) && (out_col_r == '0) &&
       (out_val_r == '0)))
    else $error("failed placement carries destination fields");

  // A counter update only happens when the working stage hands its result on.
  a_write_on_adv: assert property (@(posedge clk) disable iff (!rst_n)
    wr_ctl.wr |-> (s1_vld_r && s1_adv && off_diag))
    else $error("counter written outside a result transfer");

endmodule

[tb/sv/ellpack_transpose_placer_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ELLPACK transpose placer testbench
// Streams ELLPACK entries into the placer and checks each destination item
// against a behavioral predictor that keeps its own row fill counters and
// register copies. It covers directed corner cases, register extremes and
// random well-formed matrices mixed with noise, under several idling phases.
// ----------------------------------------------------------------------------
module ellpack_transpose_placer_tb;
  import etp_pkg::*;

  localparam int MAX_ROWS  = 1024;
  localparam int MAX_WIDTH = 64;

  // Layout of tdata on both channels, lowest field last.
  typedef struct packed {
    logic [5:0]         pad;
    logic [VALUE_W-1:0] value;
    logic [ROW_W-1:0]   col;
    logic [SLOT_W-1:0]  slot;
    logic [ROW_W-1:0]   row;
  } ell_word_t;

  typedef struct packed {
    ell_word_t   word;
    etp_status_t status;
  } placement_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [95:0] in_tdata = '0;   // src_row, src_slot, col_index, entry_value, zero
  logic [0:0]  in_tuser = '0;   // new_matrix
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [95:0] out_tdata;       // dest_row, dest_slot, dest_col, dest_value, zero
  logic [1:0]  out_tuser;       // status
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // Predictor state: register copies and the per-row fill counters.
  logic [RC_W-1:0]   rows_reg;
  logic [RW_W-1:0]   width_reg;
  logic [FILL_W-1:0] fill_count [MAX_ROWS];

  placement_t  pending_places[$];
  placement_t  want;
  ell_word_t   got;
  int          mismatches = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;

  ellpack_transpose_placer #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_WIDTH(MAX_WIDTH)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Rows and slots actually in use, with the registers clamped to legal range.
  function automatic int unsigned active_rows();
    if (rows_reg == 0) return 1;
    if (rows_reg > MAX_ROWS) return MAX_ROWS;
    return rows_reg;
  endfunction

  function automatic int unsigned active_slots();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_WIDTH) return MAX_WIDTH;
    return width_reg;
  endfunction

  // Works out where one accepted entry lands and advances the fill counters.
  function automatic placement_t place_entry(input logic fresh,
                                             input logic [ROW_W-1:0] srow,
                                             input logic [SLOT_W-1:0] sslot,
                                             input logic [ROW_W-1:0] col,
                                             input logic [VALUE_W-1:0] val);
    placement_t  p;
    int unsigned n;
    int unsigned m;
    int unsigned f;
    n = active_rows();
    m = active_slots();
    p = '0;
    p.status = ST_PLACED;
    if (fresh) begin
      foreach (fill_count[i]) fill_count[i] = FILL_W'(1);
    end
    if (srow >= n || sslot >= m) begin
      p.status = ST_RANGE;
    end else if (sslot == 0) begin
      // A diagonal entry keeps its own row and never touches a counter.
      p.word.row = srow;
    end else if (col >= n) begin
      p.status = ST_RANGE;
    end else begin
      f = fill_count[col];
      if (f >= m) begin
        p.status = ST_ROW_FULL;
      end else begin
        p.word.row = col;
        p.word.slot = SLOT_W'(f);
        fill_count[col] = FILL_W'(f + 1);
      end
    end
    if (p.status == ST_PLACED) begin
      p.word.col = srow;
      p.word.value = val;
    end
    return p;
  endfunction

  // The receiver stalls at random with the current phase's rate.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Each accepted result is compared with the oldest pending placement.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (pending_places.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: unexpected item row %0d slot %0d col %0d value %h status %0d",
                   $realtime, got.row, got.slot, got.col, got.value, out_tuser);
        mismatches++;
      end else begin
        want = pending_places.pop_front();
        if (got.row !== want.word.row || got.slot !== want.word.slot ||
            got.col !== want.word.col || got.value !== want.word.value ||
            got.pad !== want.word.pad || out_tuser !== want.status) begin
          if (mismatches < 10) begin
            $display("%0t: item mismatch, expected row %0d slot %0d col %0d value %h status %0d",
                     $realtime, want.word.row, want.word.slot, want.word.col,
                     want.word.value, want.status);
            $display("%0t:                    got row %0d slot %0d col %0d value %h status %0d",
                     $realtime, got.row, got.slot, got.col, got.value, out_tuser);
          end
          mismatches++;
        end
      end
    end
  end

  // Sends one entry, with a random gap first, and records its placement.
  task automatic send_entry(input logic fresh, input logic [ROW_W-1:0] srow,
                            input logic [SLOT_W-1:0] sslot, input logic [ROW_W-1:0] col,
                            input logic [VALUE_W-1:0] val);
    ell_word_t w;
    w = '{pad: '0, value: val, col: col, slot: sslot, row: srow};
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= w;
    in_tuser <= fresh;
    do @(posedge clk); while (!in_tready);
    pending_places.push_back(place_entry(fresh, srow, sslot, col, val));
  endtask

  // Stops sending and waits until every pending item has come back.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_places.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Writes one register over the configuration port and reads it back.
  task automatic write_reg(input etp_reg_t idx, input logic [31:0] val);
    logic [31:0] readback;
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (idx == REG_ROW_COUNT) rows_reg = val[RC_W-1:0];
    else width_reg = val[RW_W-1:0];
    readback = (idx == REG_ROW_COUNT) ? 32'(rows_reg) : 32'(width_reg);
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== readback) begin
      if (mismatches < 10)
        $display("%0t: register %s read %h, expected %h",
                 $realtime, idx.name(), cfg_prdata, readback);
      mismatches++;
    end
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic [31:0] rows, input logic [31:0] slots);
    drain();
    write_reg(REG_ROW_COUNT, rows);
    write_reg(REG_ROW_WIDTH, slots);
  endtask

  // Corner cases under the reset register values.
  task automatic test_reset_placement();
    send_entry(1'b1, 10'd0, 6'd0, 10'd0, 64'd0);
    send_entry(1'b0, 10'd1023, 6'd0, 10'd1023, '1);
    send_entry(1'b0, 10'd0, 6'd1, 10'd1023, 64'hA5A5_5A5A_F00F_0FF0);
    send_entry(1'b0, 10'd1023, 6'd63, 10'd0, 64'h5A5A_A5A5_0FF0_F00F);
    // Off-diagonal entries that name their own row.
    send_entry(1'b0, 10'd7, 6'd1, 10'd7, 64'h1);
    send_entry(1'b0, 10'd7, 6'd2, 10'd7, 64'h8000_0000_0000_0000);
    // A diagonal entry carrying a foreign column index.
    send_entry(1'b0, 10'd3, 6'd0, 10'd9, 64'h1234_5678_9ABC_DEF0);
    send_entry(1'b1, 10'd2, 6'd1, 10'd7, 64'hFEDC_BA98_7654_3210);
  endtask

  // A small matrix: a row filling up, and each kind of index out of range.
  task automatic test_fill_limits();
    configure(32'd4, 32'd3);
    send_entry(1'b0, 10'd0, 6'd1, 10'd2, 64'h11);
    send_entry(1'b0, 10'd1, 6'd2, 10'd2, 64'h22);
    send_entry(1'b0, 10'd3, 6'd1, 10'd2, 64'h33);
    send_entry(1'b0, 10'd4, 6'd0, 10'd0, 64'h44);
    send_entry(1'b0, 10'd0, 6'd3, 10'd1, 64'h55);
    send_entry(1'b0, 10'd0, 6'd1, 10'd4, 64'h66);
    send_entry(1'b0, 10'd1, 6'd0, 10'd1023, 64'h77);
    send_entry(1'b1, 10'd3, 6'd2, 10'd2, 64'h88);
  endtask

  // Register values below and above the legal range are clamped.
  task automatic test_register_extremes();
    configure(32'd0, 32'd0);
    send_entry(1'b0, 10'd0, 6'd0, 10'd0, 64'h99);
    send_entry(1'b0, 10'd0, 6'd1, 10'd0, 64'hAA);
    send_entry(1'b0, 10'd1, 6'd0, 10'd0, 64'hBB);
    configure(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_entry(1'b0, 10'd1023, 6'd63, 10'd1023, '1);
    send_entry(1'b1, 10'd1023, 6'd63, 10'd1023, 64'hCC);
  endtask

  // Random matrices in row-major order, mixed with stray indexes and noise.
  task automatic test_random_matrices(input int budget);
    int unsigned n;
    int unsigned m;
    int unsigned nrows;
    int unsigned base;
    int unsigned k;
    int unsigned col;
    int          sent;
    bit          paused;
    n = active_rows();
    m = active_slots();
    sent = 0;
    paused = 1'b0;
    while (sent < budget) begin
      if ($urandom_range(99) < 80) begin
        nrows = $urandom_range(1, (n < 20) ? n : 20);
        base = $urandom_range(0, n - nrows);
        for (int unsigned r = base; r < base + nrows && sent < budget; r++) begin
          k = ($urandom_range(9) == 0) ? m : $urandom_range(1, (m < 10) ? m : 10);
          for (int unsigned s = 0; s < k && sent < budget; s++) begin
            if ($urandom_range(99) < 8) col = $urandom_range(0, 1023);
            else col = $urandom_range(base, base + nrows - 1);
            send_entry(r == base && s == 0, ROW_W'(r), SLOT_W'(s), ROW_W'(col),
                       {$urandom, $urandom});
            sent++;
          end
        end
      end else begin
        send_entry($urandom_range(19) == 0, ROW_W'($urandom_range(0, 1023)),
                   SLOT_W'($urandom_range(0, 63)), ROW_W'($urandom_range(0, 1023)),
                   {$urandom, $urandom});
        sent++;
      end
      // Halfway through, let the pipeline run dry once.
      if (!paused && sent >= budget / 2) begin
        drain();
        paused = 1'b1;
      end
    end
  endtask

  initial begin
    rows_reg = RC_RESET;
    width_reg = RW_RESET;
    foreach (fill_count[i]) fill_count[i] = FILL_W'(1);
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_placement();
    test_fill_limits();
    test_register_extremes();

    configure(32'd1024, 32'd64);
    test_random_matrices(190);

    configure(32'd12, 32'd5);
    send_idle_pct = 47;
    test_random_matrices(190);

    configure(32'd300, 32'd20);
    send_idle_pct = 0;
    recv_stall_pct = 47;
    test_random_matrices(190);

    configure($urandom_range(1, 40), $urandom_range(1, 12));
    send_idle_pct = 22;
    recv_stall_pct = 22;
    test_random_matrices(190);

    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending_places.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
